FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the oscillator top level. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion %m failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/msso_pkg.sv
// ----------------------------------------------------------------------------
// msso_pkg
// Types, constants and the sine table of the servo sine oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package msso_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF   = 4;
  localparam int PHASE_BITS_DEF = 16;

  // Fixed design constants
  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int SAMPLE_MS          = 30;
  localparam int IDX_W              = $clog2(SINE_TABLE_ENTRIES);
  localparam int SINE_W             = 16;
  localparam int CHAN_W             = 2;
  localparam int PERIOD_W           = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 64;

  // floor(period / SAMPLE_MS) = (period * PERIOD_RECIP) >> PERIOD_SH, exact for 16-bit periods
  localparam int PERIOD_SH    = 26;
  localparam int RECIP_W      = 27;
  localparam logic [RECIP_W-1:0] PERIOD_RECIP =
    RECIP_W'((2**PERIOD_SH + SAMPLE_MS - 1) / SAMPLE_MS);

  // floor(t * 17 / 12) = (t * SCALE_MUL) >> SCALE_SH, exact for t below 65536
  localparam int SCALE_SH  = 18;
  localparam int SCALE_W   = 19;
  localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'((17 * 2**SCALE_SH + 11) / 12);

  // Fixed-point sine table generation
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDES    = 3'd0,
    CFG_OFFSETS       = 3'd1,
    CFG_PHASE_OFFSETS = 3'd2,
    CFG_PERIODS       = 3'd3,
    CFG_REVERSE_MASK  = 3'd4,
    CFG_TRIMS         = 3'd5,
    CFG_STOP_MASK     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] amplitudes;
    logic [31:0] offsets;
    logic [63:0] phase_offsets;
    logic [63:0] periods;
    logic [3:0]  reverse_mask;
    logic [31:0] trims;
    logic [3:0]  stop_mask;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    amplitudes:    32'h2D2D_2D2D,
    offsets:       32'h0,
    phase_offsets: 64'h0,
    periods:       64'h07D0_07D0_07D0_07D0,
    reverse_mask:  4'h0,
    trims:         32'h0,
    stop_mask:     4'h0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } state_e;

  typedef logic [SINE_TABLE_ENTRIES-1:0][SINE_W-1:0] sine_tab_t;

  // sin(pi/2 * r / ENTRIES) in Q30, Taylor series to x^11
  function automatic longint quarter_sin_q30(longint r);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (HALF_PI_Q30 * r) / SINE_TABLE_ENTRIES;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return sum;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    q;
    longint    r;
    longint    s;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      q = (4 * k) / SINE_TABLE_ENTRIES;
      r = (4 * k) % SINE_TABLE_ENTRIES;
      if (q % 2 == 1) begin
        r = SINE_TABLE_ENTRIES - r;
      end
      s = (quarter_sin_q30(r) * 32767 + (ONE_Q30 / 2)) >>> 30;
      tab[k] = SINE_W'((q >= 2) ? -s : s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

FILE: rtl/msso_ram.sv
// ----------------------------------------------------------------------------
// msso_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msso_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                    wdata_i,
  input  wire logic                                re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/msso_div.sv
// ----------------------------------------------------------------------------
// msso_div
// Phase increment divider: 2^PHASE_BITS / divisor, radix 4 restoring,
// two quotient bits per cycle. A zero divisor gives a zero increment.
// ----------------------------------------------------------------------------
`default_nettype none

module msso_div #(
  parameter int PHASE_BITS = msso_pkg::PHASE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [msso_pkg::PERIOD_W-1:0] divisor_i,
  output logic                               done_o,
  output logic      [PHASE_BITS-1:0]         quot_o
);

  localparam int NW    = (PHASE_BITS + 2) / 2;   // iterations
  localparam int DW    = 2 * NW;                 // padded dividend width
  localparam int CNT_W = $clog2(NW + 1);
  localparam int RW    = msso_pkg::PERIOD_W;
  localparam logic [DW-1:0] DVD_INIT = DW'(1) << PHASE_BITS;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvd_q, dvd_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [RW-1:0]    dsr_q;
  logic             zero_q;
  logic [RW:0]      trial;

  // two restoring steps per cycle
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, dvd_d[DW-1]};
      dvd_d = {dvd_d[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = RW'(trial - {1'b0, dsr_q});
        quo_d = {quo_d[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[RW-1:0];
        quo_d = {quo_d[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvd_q  <= DVD_INIT;
      quo_q  <= '0;
      dsr_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = !busy_q;
  assign quot_o = zero_q ? '0 : quo_q[PHASE_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/msso_cfg.sv
// ----------------------------------------------------------------------------
// msso_cfg
// Configuration register file, write only, indexed.
// ----------------------------------------------------------------------------
`default_nettype none

module msso_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [msso_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [msso_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output msso_pkg::cfg_t                       cfg_o
);

  msso_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= msso_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (msso_pkg::cfg_idx_e'(cfg_index_i))
        msso_pkg::CFG_AMPLITUDES:    cfg_q.amplitudes    <= cfg_data_i[31:0];
        msso_pkg::CFG_OFFSETS:       cfg_q.offsets       <= cfg_data_i[31:0];
        msso_pkg::CFG_PHASE_OFFSETS: cfg_q.phase_offsets <= cfg_data_i;
        msso_pkg::CFG_PERIODS:       cfg_q.periods       <= cfg_data_i;
        msso_pkg::CFG_REVERSE_MASK:  cfg_q.reverse_mask  <= cfg_data_i[3:0];
        msso_pkg::CFG_TRIMS:         cfg_q.trims         <= cfg_data_i[31:0];
        msso_pkg::CFG_STOP_MASK:     cfg_q.stop_mask     <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/multichannel_servo_sine_oscillator_top.sv
// ----------------------------------------------------------------------------
// multichannel_servo_sine_oscillator_top
// Time from request accept to result valid is set by the radix-4 increment divider.
// Requests: one in flight at a time; the output register frees the input side.
// Reset: asynchronous, active low; config registers take their defaults and
//   all phase accumulators read as zero (per-channel valid bits).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multichannel_servo_sine_oscillator_top #(
  parameter int CHANNELS   = msso_pkg::CHANNELS_DEF,
  parameter int PHASE_BITS = msso_pkg::PHASE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [msso_pkg::CHAN_W-1:0]     channel_i,
  input  wire logic                            hold_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [msso_pkg::CHAN_W-1:0]     out_channel_o,
  output logic      [7:0]                      position_o,
  output logic                                 position_valid_o,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [msso_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [msso_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW     = msso_pkg::CHAN_W;
  localparam int EW     = AW + CW;
  localparam int PW     = msso_pkg::PERIOD_W;
  localparam int PROD_W = PW + msso_pkg::RECIP_W;
  localparam int SW     = msso_pkg::SINE_W;
  localparam int V_W    = 25;   // a*sin + off*2^15 needs 25 signed bits
  localparam int D_W    = 10;   // rounded degree magnitude
  localparam int T_W    = 12;   // deg + 90 + trim
  localparam int SC_W   = (T_W - 1) + msso_pkg::SCALE_W;
  localparam int SQ_W   = SC_W - msso_pkg::SCALE_SH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  msso_pkg::cfg_t cfg;

  msso_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // IDLE  : take a request, issue the accumulator read, form period*recip
  // LOOK  : read data back, look up the sine, start the increment divide
  // MUL   : a*sin + offset
  // SCALE : round to degrees, reverse, add 90 and trim
  // DONE  : scale by 17/12, saturate, write back acc+inc, load the output
  // --------------------------------------------------------------------------
  msso_pkg::state_e state_q, state_d;

  logic in_acc;
  logic out_free;
  logic finish;
  logic div_done;
  logic out_valid_q;

  assign in_acc     = in_valid_i && (state_q == msso_pkg::ST_IDLE);
  assign in_stall_o = (state_q != msso_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == msso_pkg::ST_DONE) && div_done && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      msso_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = msso_pkg::ST_LOOK;
        end
      end
      msso_pkg::ST_LOOK:  state_d = msso_pkg::ST_MUL;
      msso_pkg::ST_MUL:   state_d = msso_pkg::ST_SCALE;
      msso_pkg::ST_SCALE: state_d = msso_pkg::ST_DONE;
      msso_pkg::ST_DONE: begin
        if (finish) begin
          state_d = msso_pkg::ST_IDLE;
        end
      end
      default: state_d = msso_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msso_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Request capture and channel decode
  // --------------------------------------------------------------------------
  logic [CW-1:0]     ch_q;
  logic              hold_q;
  logic [PROD_W-1:0] prod_q;
  logic [EW-1:0]     ch_ext_in, ch_ext_q;
  logic [AW-1:0]     raddr, addr_q;
  logic              chan_ok;
  logic [PW-1:0]     period_in;

  assign ch_ext_in = {{AW{1'b0}}, channel_i};
  assign ch_ext_q  = {{AW{1'b0}}, ch_q};
  assign raddr     = ch_ext_in[AW-1:0];
  assign addr_q    = ch_ext_q[AW-1:0];
  assign chan_ok   = (ch_ext_q < EW'(CHANNELS));
  assign period_in = cfg.periods[{channel_i, 4'b0000} +: PW];

  // --------------------------------------------------------------------------
  // Phase accumulator memory; valid bits make never-written entries read zero
  // --------------------------------------------------------------------------
  logic                  mem_we;
  logic [PHASE_BITS-1:0] mem_rdata;
  logic [PHASE_BITS-1:0] mem_wdata;
  logic [CHANNELS-1:0]   vld_q;
  logic [PHASE_BITS-1:0] acc_rd;
  logic [PHASE_BITS-1:0] acc_q;
  logic [PHASE_BITS-1:0] inc;

  assign mem_we    = finish && chan_ok && !hold_q;
  assign mem_wdata = acc_q + inc;
  assign acc_rd    = vld_q[addr_q] ? mem_rdata : '0;

  msso_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Increment: 2^PHASE_BITS / floor(period / SAMPLE_MS)
  // --------------------------------------------------------------------------
  logic [PW-1:0] nsteps;

  assign nsteps = prod_q[msso_pkg::PERIOD_SH +: PW];

  msso_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == msso_pkg::ST_LOOK),
    .divisor_i (nsteps),
    .done_o    (div_done),
    .quot_o    (inc)
  );

  // --------------------------------------------------------------------------
  // Sine path
  // --------------------------------------------------------------------------
  logic [PW+PHASE_BITS-1:0] ph0_wide;
  logic [PHASE_BITS-1:0]    tot;
  logic [msso_pkg::IDX_W-1:0] sine_idx;
  logic signed [SW-1:0]     sine_q;
  logic [7:0]               amp, off, trim;
  logic signed [V_W-1:0]    mul_term, off_term, v_d, v_q;
  logic [V_W-1:0]           vabs, vround;
  logic [D_W-1:0]           dmag;
  logic                     neg;
  logic signed [T_W-1:0]    dsigned, t_d, t_q;
  logic [SC_W-1:0]          scaled;
  logic [SQ_W-1:0]          sq;
  logic [7:0]               pos;
  logic                     emit;

  // start phase rescaled to PHASE_BITS, truncated
  assign ph0_wide = {cfg.phase_offsets[{ch_q, 4'b0000} +: PW], {PHASE_BITS{1'b0}}};
  assign tot      = acc_rd + ph0_wide[PW +: PHASE_BITS];
  assign sine_idx = tot[PHASE_BITS-1 -: msso_pkg::IDX_W];

  assign amp  = cfg.amplitudes[{ch_q, 3'b000} +: 8];
  assign off  = cfg.offsets[{ch_q, 3'b000} +: 8];
  assign trim = cfg.trims[{ch_q, 3'b000} +: 8];

  assign mul_term = $signed({1'b0, amp}) * sine_q;
  assign off_term = $signed({{2{off[7]}}, off, 15'd0});
  assign v_d      = mul_term + off_term;

  // round half away from zero on the magnitude, then reapply the sign
  assign vabs    = v_q[V_W-1] ? V_W'(-v_q) : V_W'(v_q);
  assign vround  = vabs + V_W'(16384);
  assign dmag    = vround[15 +: D_W];
  assign neg     = v_q[V_W-1] ^ cfg.reverse_mask[ch_q];
  assign dsigned = neg ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
  assign t_d     = dsigned + T_W'(90) + $signed({{(T_W-8){trim[7]}}, trim});

  // 17/12 scaling by reciprocal multiply, zero for t <= 0, clip at 255
  assign scaled = t_q[T_W-2:0] * msso_pkg::SCALE_MUL;
  assign sq     = scaled[msso_pkg::SCALE_SH +: SQ_W];
  assign pos    = (t_q[T_W-1] || (t_q == '0)) ? 8'd0 :
                  (sq > SQ_W'(255)) ? 8'd255 : sq[7:0];
  assign emit   = chan_ok && !hold_q && !cfg.stop_mask[ch_q];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= channel_i;
      hold_q <= hold_i;
      prod_q <= period_in * msso_pkg::PERIOD_RECIP;
    end
    if (state_q == msso_pkg::ST_LOOK) begin
      acc_q  <= acc_rd;
      sine_q <= $signed(msso_pkg::SINE_TAB[sine_idx]);
    end
    if (state_q == msso_pkg::ST_MUL) begin
      v_q <= v_d;
    end
    if (state_q == msso_pkg::ST_SCALE) begin
      t_q <= t_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [CW-1:0] out_chan_q;
  logic [7:0]    pos_q;
  logic          pvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_chan_q <= ch_q;
      pos_q      <= emit ? pos : 8'd0;
      pvalid_q   <= emit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_chan_q;
  assign position_o       = pos_q;
  assign position_valid_o = pvalid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEVER(a_no_rw_overlap, clk_i, rst_ni, mem_we && in_acc)
  `ASSERT_PROP(a_wb_not_held, clk_i, rst_ni, mem_we |-> (!hold_q && chan_ok))
  `ASSERT_PROP(a_idle_pos_zero, clk_i, rst_ni,
               (out_valid_o && !position_valid_o) |-> (position_o == 8'd0))
  `ASSERT_PROP(a_accept_reads, clk_i, rst_ni, in_acc |=> (state_q == msso_pkg::ST_LOOK))

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Servo sine oscillator testbench
// Sends tick requests through the valid/stall request channel and checks each
// servo command against an in-bench model of the four phase accumulators, the
// Q1.15 sine table and the degree-to-servo-byte scaling. Registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0] chan;
  logic [7:0] position;
  logic       written;
} servo_cmd_t;

class servo_scoreboard;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam int     TICK_MS     = 30;

  msso_pkg::cfg_t regs;
  logic [15:0]    phase_acc [4];
  int             sine_q15 [256];
  servo_cmd_t     pending_cmds [$];
  int             mismatches;

  function new();
    build_sine();
    regs = '0;
    regs.amplitudes = 32'h2D2D_2D2D;
    regs.periods    = 64'h07D0_07D0_07D0_07D0;
    foreach (phase_acc[i]) phase_acc[i] = '0;
    mismatches = 0;
  endfunction

  // Quarter-wave Taylor series to x^11, mirrored into the full table.
  function void build_sine();
    longint q, r, s, x, x2, term, sum;
    for (int k = 0; k < 256; k++) begin
      q = (4 * k) / 256;
      r = (4 * k) % 256;
      if (q % 2 == 1) begin
        r = 256 - r;
      end
      x    = (HALF_PI_Q30 * r) / 256;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int j = 1; j <= 5; j++) begin
        term = ((term * x2) >>> 30) / ((2 * j) * (2 * j + 1));
        sum  = (j % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > ONE_Q30) begin
        sum = ONE_Q30;
      end
      s = (sum * 32767 + ONE_Q30 / 2) >>> 30;
      sine_q15[k] = int'((q >= 2) ? -s : s);
    end
  endfunction

  function void write_reg(msso_pkg::cfg_idx_e idx, logic [63:0] data);
    case (idx)
      msso_pkg::CFG_AMPLITUDES:    regs.amplitudes    = data[31:0];
      msso_pkg::CFG_OFFSETS:       regs.offsets       = data[31:0];
      msso_pkg::CFG_PHASE_OFFSETS: regs.phase_offsets = data;
      msso_pkg::CFG_PERIODS:       regs.periods       = data;
      msso_pkg::CFG_REVERSE_MASK:  regs.reverse_mask  = data[3:0];
      msso_pkg::CFG_TRIMS:         regs.trims         = data[31:0];
      msso_pkg::CFG_STOP_MASK:     regs.stop_mask     = data[3:0];
      default: ;
    endcase
  endfunction

  // Accepted tick: work out the servo command and advance the phase.
  function void note_tick(logic [1:0] chan, logic hold);
    servo_cmd_t  cmd;
    logic [15:0] acc, ph0, period, step, total;
    int          nsteps;
    longint      v, deg, t;
    cmd      = '0;
    cmd.chan = chan;
    if (!hold) begin
      acc    = phase_acc[chan];
      ph0    = regs.phase_offsets[16*chan +: 16];
      period = regs.periods[16*chan +: 16];
      nsteps = int'(period) / TICK_MS;
      step   = (nsteps != 0) ? 16'(65536 / nsteps) : 16'd0;
      if (!regs.stop_mask[chan]) begin
        total = acc + ph0;
        v = longint'(regs.amplitudes[8*chan +: 8]) * sine_q15[total[15:8]]
          + longint'($signed(regs.offsets[8*chan +: 8])) * 32768;
        deg = (v >= 0) ? (v + 16384) / 32768 : -((-v + 16384) / 32768);
        if (regs.reverse_mask[chan]) begin
          deg = -deg;
        end
        t = deg + 90 + longint'($signed(regs.trims[8*chan +: 8]));
        t = (t > 0) ? (t * 17) / 12 : 0;
        if (t > 255) begin
          t = 255;
        end
        cmd.position = 8'(t);
        cmd.written  = 1'b1;
      end
      phase_acc[chan] = acc + step;
    end
    pending_cmds.push_back(cmd);
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function void check_position(logic [1:0] chan, logic [7:0] position, logic written);
    servo_cmd_t want;
    if (pending_cmds.size() == 0) begin
      flag($sformatf("unexpected command: chan %0d pos %0d written %0b",
                     chan, position, written));
    end else begin
      want = pending_cmds.pop_front();
      if (chan !== want.chan || position !== want.position || written !== want.written) begin
        flag($sformatf({"command mismatch: expected chan %0d pos %0d written %0b,",
                        " got chan %0d pos %0d written %0b"},
                       want.chan, want.position, want.written, chan, position, written));
      end
    end
  endfunction

  function int pending();
    return pending_cmds.size();
  endfunction
endclass

module testbench;

  // DUT-facing signals
  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [msso_pkg::CHAN_W-1:0]       channel_i;
  logic                              hold_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [msso_pkg::CHAN_W-1:0]       out_channel_o;
  logic [7:0]                        position_o;
  logic                              position_valid_o;
  logic                              cfg_we_i;
  logic [msso_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [msso_pkg::CFG_DATA_W-1:0]   cfg_data_i;

  // Percent of cycles the request side sits idle / the result side stalls
  int send_idle_pct;
  int recv_stall_pct;

  servo_scoreboard servo_sb;

  multichannel_servo_sine_oscillator_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .channel_i        (channel_i),
    .hold_i           (hold_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .position_o       (position_o),
    .position_valid_o (position_valid_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Result side: values read right after the edge are the ones the edge saw,
  // since everything here and in the block updates through nonblocking writes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      servo_sb.check_position(out_channel_o, position_o, position_valid_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // One tick request. Idle cycles carry junk on the payload with valid low;
  // once valid is up the payload holds until the stall drops.
  task automatic send_tick(logic [1:0] chan, logic hold);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      channel_i  <= 2'($urandom);
      hold_i     <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= chan;
    hold_i     <= hold;
    do @(posedge clk_i); while (in_stall_o);
    servo_sb.note_tick(chan, hold);
  endtask

  // Drop valid and wait until every expected command has come back. Every
  // tick yields a command, so an empty queue means the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (servo_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(msso_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    servo_sb.write_reg(idx, data);
  endtask

  // Back-to-back writes; write enable drops once after the last one.
  task automatic apply_config(msso_pkg::cfg_t c);
    write_reg(msso_pkg::CFG_AMPLITUDES,    64'(c.amplitudes));
    write_reg(msso_pkg::CFG_OFFSETS,       64'(c.offsets));
    write_reg(msso_pkg::CFG_PHASE_OFFSETS, c.phase_offsets);
    write_reg(msso_pkg::CFG_PERIODS,       c.periods);
    write_reg(msso_pkg::CFG_REVERSE_MASK,  64'(c.reverse_mask));
    write_reg(msso_pkg::CFG_TRIMS,         64'(c.trims));
    write_reg(msso_pkg::CFG_STOP_MASK,     64'(c.stop_mask));
    cfg_we_i <= 1'b0;
  endtask

  // Register value of the given width: now and then all zeros or all ones.
  function automatic logic [63:0] pick_bits(int width);
    logic [63:0] mask;
    mask = (64'd1 << width) - 64'd1;
    case ($urandom_range(9))
      0:       return '0;
      1:       return mask;
      default: return {$urandom, $urandom} & mask;
    endcase
  endfunction

  function automatic msso_pkg::cfg_t random_config();
    msso_pkg::cfg_t c;
    c.amplitudes    = 32'(pick_bits(32));
    c.offsets       = 32'(pick_bits(32));
    c.phase_offsets = pick_bits(64);
    c.reverse_mask  = 4'(pick_bits(4));
    c.trims         = 32'(pick_bits(32));
    c.stop_mask     = 4'(pick_bits(4));
    // Periods per channel: below one tick (no phase motion), a couple of
    // ticks (big jumps), typical gait periods, anything, and the maximum.
    for (int ch = 0; ch < 4; ch++) begin
      case ($urandom_range(4))
        0:       c.periods[16*ch +: 16] = 16'($urandom_range(0, 29));
        1:       c.periods[16*ch +: 16] = 16'($urandom_range(30, 90));
        2:       c.periods[16*ch +: 16] = 16'($urandom_range(91, 2000));
        3:       c.periods[16*ch +: 16] = 16'($urandom);
        default: c.periods[16*ch +: 16] = 16'hFFFF;
      endcase
    end
    return c;
  endfunction

  initial begin
    msso_pkg::cfg_t edge_cfg;
    servo_sb       = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i    <= 1'b0;
    channel_i     <= '0;
    hold_i        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= msso_pkg::CFG_AMPLITUDES;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults after reset: a tick per channel, then held ticks that must
    // leave the phase alone.
    for (int ch = 0; ch < 4; ch++) begin
      send_tick(2'(ch), 1'b0);
    end
    send_tick(2'd0, 1'b1);
    send_tick(2'd3, 1'b1);
    drain();

    // Corner settings:
    //   ch0 full amplitude, max offset and trim at the sine peak -> clips at 255
    //   ch1 full amplitude, min offset and trim at the trough -> clips at 0,
    //       zero period so the phase never moves
    //   ch2 reversed, one-tick period (increment wraps to zero)
    //   ch3 stopped, half-turn steps keep running underneath
    edge_cfg.amplitudes    = 32'h0000_40FF | 32'h0000_FF00;
    edge_cfg.amplitudes    = 32'h0040_FFFF;
    edge_cfg.offsets       = 32'h8000_807F;
    edge_cfg.phase_offsets = 64'hFFFF_4000_C000_4000;
    edge_cfg.periods       = 64'h003C_001E_0000_FFFF;
    edge_cfg.reverse_mask  = 4'b0100;
    edge_cfg.trims         = 32'h7F00_807F;
    edge_cfg.stop_mask     = 4'b1000;
    apply_config(edge_cfg);
    repeat (3) begin
      for (int ch = 0; ch < 4; ch++) begin
        send_tick(2'(ch), 1'b0);
      end
    end
    for (int ch = 0; ch < 4; ch++) begin
      send_tick(2'(ch), 1'b1);
    end
    drain();

    // Random ticks under random settings, one idling pattern per pass.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int k = 0; k < 3; k++) begin
        apply_config(random_config());
        repeat (62) begin
          send_tick(2'($urandom), ($urandom_range(99) < 15));
        end
        drain();
      end
    end

    // Give a stray extra command time to show up.
    repeat (24) @(posedge clk_i);
    if (servo_sb.mismatches == 0 && servo_sb.pending() == 0) begin
      $display("** multichannel_servo_sine_oscillator_top: PASSED **");
    end else begin
      $display("** multichannel_servo_sine_oscillator_top: FAILED **");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("** multichannel_servo_sine_oscillator_top: FAILED **");
    $finish;
  end

endmodule
